@@ rtl/onb_pkg.sv @@
// onb_pkg: shared types, fixed-point constants and per-stage datapath functions
// for the Oren-Nayar reflectance pipeline; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package onb_pkg;

   localparam int VEC_FRAC_BITS    = 15;
   localparam int ACOS_TABLE_DEPTH = 256;
   localparam int IDX_BITS         = $clog2(ACOS_TABLE_DEPTH + 1);
   localparam int DOT_RSH          = (2 * VEC_FRAC_BITS >= 30) ? 2 * VEC_FRAC_BITS - 30 : 0;
   localparam int DOT_LSH          = (2 * VEC_FRAC_BITS >= 30) ? 0 : 30 - 2 * VEC_FRAC_BITS;

   // stage schedule
   localparam int ST_PROD     = 1;
   localparam int ST_DOT      = 2;
   localparam int ST_MUL0     = 3;
   localparam int ST_PREP     = 4;
   localparam int WD_FIRST    = 4;
   localparam int WD_LAST     = 34;
   localparam int SQ_FIRST    = 5;
   localparam int SQ_LAST     = 36;
   localparam int ST_W        = 35;
   localparam int ST_TW       = 36;
   localparam int ST_ARG      = 37;
   localparam int ST_ROM      = 38;
   localparam int ST_INTERP   = 39;
   localparam int ST_THETA    = 40;
   localparam int ST_INNER    = 41;
   localparam int QD_FIRST    = 41;
   localparam int QD_LAST     = 73;
   localparam int ST_TERM1    = 42;
   localparam int ST_QCLAMP   = 74;
   localparam int ST_G        = 75;
   localparam int ST_E        = 76;
   localparam int ST_E1       = 77;
   localparam int ST_MC       = 78;
   localparam int ST_NM       = 79;
   localparam int PIPE_LAST   = 80;

   localparam logic [1:0] CSR_COEF_A = 2'd0;
   localparam logic [1:0] CSR_COEF_B = 2'd1;

   localparam logic [15:0] COEF_A_RESET = 16'd20861;
   localparam logic [15:0] COEF_B_RESET = 16'd0;

   typedef logic signed [39:0] q_type;

   localparam q_type ONE_Q        = 40'sd1073741824;
   localparam q_type PI_Q         = 40'sd3373259426;
   localparam q_type HALF_PI_Q    = 40'sd1686629713;
   localparam q_type INV_PI_Q     = 40'sd341782638;
   localparam q_type TWO_THIRDS_Q = 40'sd715827883;
   localparam q_type EPS_Q        = 40'sd1074;
   localparam logic [32:0] GRAZE_MAX_Q = 33'h1_0000_0000;

   typedef struct packed {
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
      logic signed [15:0] normal_z;
      logic signed [15:0] view_x;
      logic signed [15:0] view_y;
      logic signed [15:0] view_z;
      logic signed [15:0] light_x;
      logic signed [15:0] light_y;
      logic signed [15:0] light_z;
      logic [15:0]        multi_red;
      logic [15:0]        multi_green;
      logic [15:0]        multi_blue;
   } req_word_type;

   typedef struct packed {
      logic [15:0] value_red;
      logic [15:0] value_green;
      logic [15:0] value_blue;
      logic [15:0] density;
   } rsp_word_type;

   typedef struct packed {
      logic [1:0]  index;
      logic [15:0] wdata;
   } csr_word_type;

   typedef struct packed {
      req_word_type          word;
      logic [8:0][31:0]      prod;
      logic signed [31:0]    nl;
      logic signed [31:0]    nv;
      logic signed [31:0]    lv;
      q_type                 pdf_q;
      logic [15:0]           pdf;
      q_type                 nlnv;
      q_type                 uc2;
      q_type                 va;
      q_type                 m;
      q_type                 t;
      logic [63:0]           wd_rem;
      logic [30:0]           wd_quo;
      logic [63:0]           sq_v;
      logic [63:0]           sq_res;
      q_type                 w;
      q_type                 tw;
      q_type                 vb;
      q_type                 s;
      q_type                 su;
      q_type                 ss;
      q_type                 s3;
      q_type                 p;
      logic                  sel_hi;
      logic [IDX_BITS-1:0]   idx;
      logic [29:0]           frac;
      logic [30:0]           t0;
      logic [30:0]           t1;
      q_type                 asin;
      q_type                 theta;
      q_type                 inner;
      q_type                 term1;
      logic [63:0]           qd_rem;
      logic [32:0]           qd_quo;
      logic                  qd_ovf;
      logic [32:0]           q;
      q_type                 g;
      q_type                 ea;
      q_type                 eb;
      q_type                 e1;
      logic [2:0][39:0]      mc;
      logic [2:0][39:0]      nm;
      rsp_word_type          rsp;
   } item_type;

   typedef logic [30:0] rom_type [0:ACOS_TABLE_DEPTH];

   function automatic logic signed [63:0] sine_q(logic [63:0] x);
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [63:0] sum;
      x2   = (x * x) >> 30;
      term = x;
      sum  = $signed(x);
      for (int k = 1; k <= 11; k++) begin
         term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
         if ((k & 1) == 1) begin
            sum = sum - $signed(term);
         end else begin
            sum = sum + $signed(term);
         end
      end
      return sum;
   endfunction

   function automatic rom_type build_asin_rom();
      rom_type            rom;
      logic [63:0]        lo;
      logic [63:0]        hi;
      logic [63:0]        mid;
      logic signed [63:0] u;
      for (int i = 0; i <= ACOS_TABLE_DEPTH; i++) begin
         u  = $signed((64'(i) << 30) / 64'(ACOS_TABLE_DEPTH));
         lo = 64'd0;
         hi = 64'd1686629713;
         for (int j = 0; j < 32; j++) begin
            mid = (lo + hi) >> 1;
            if (sine_q(mid) < u) begin
               lo = mid;
            end else begin
               hi = mid;
            end
         end
         rom[i] = hi[30:0];
      end
      return rom;
   endfunction

   localparam rom_type ASIN_ROM = build_asin_rom();

   // sign-magnitude multiply, truncating toward zero
   function automatic q_type smul(q_type x, q_type y, int sh);
      logic [39:0] ux;
      logic [39:0] uy;
      logic [79:0] pr;
      logic [39:0] pm;
      logic        neg;
      neg = (x < 0) != (y < 0);
      ux  = (x < 0) ? $unsigned(-x) : $unsigned(x);
      uy  = (y < 0) ? $unsigned(-y) : $unsigned(y);
      pr  = 80'(ux) * 80'(uy);
      pm  = 40'(pr >> sh);
      return neg ? -$signed(pm) : $signed(pm);
   endfunction

   function automatic logic signed [31:0] dot3(logic [31:0] p0, logic [31:0] p1,
                                               logic [31:0] p2);
      logic signed [33:0] acc;
      logic [63:0]        mag;
      acc = 34'($signed(p0)) + 34'($signed(p1)) + 34'($signed(p2));
      mag = (acc < 0) ? 64'($unsigned(-acc)) : 64'($unsigned(acc));
      mag = (mag >> DOT_RSH) << DOT_LSH;
      if (mag > 64'(ONE_Q)) begin
         mag = 64'(ONE_Q);
      end
      return (acc < 0) ? -$signed(32'(mag)) : $signed(32'(mag));
   endfunction

   function automatic logic [15:0] to_q16(q_type x);
      logic [39:0] r;
      if (x <= 0) begin
         return 16'd0;
      end
      r = ($unsigned(x) + 40'd8192) >> 14;
      return (r > 40'd65535) ? 16'hFFFF : r[15:0];
   endfunction

   // work done by pipeline stage k on the word coming from stage k-1
   function automatic item_type step_fn(int k, item_type x, logic [15:0] coef_a,
                                        logic [15:0] coef_b);
      item_type           y;
      logic signed [15:0] n [3];
      logic signed [15:0] v [3];
      logic signed [15:0] l [3];
      logic [15:0]        mch [3];
      q_type              a;
      q_type              b;
      q_type              nl;
      q_type              arg;
      logic [63:0]        d;
      logic [63:0]        bit_v;
      logic [63:0]        pos;
      logic [60:0]        ip;
      logic [63:0]        gq;
      int                 j;
      y = x;
      n[0] = x.word.normal_x; n[1] = x.word.normal_y; n[2] = x.word.normal_z;
      v[0] = x.word.view_x;   v[1] = x.word.view_y;   v[2] = x.word.view_z;
      l[0] = x.word.light_x;  l[1] = x.word.light_y;  l[2] = x.word.light_z;
      mch[0] = x.word.multi_red;
      mch[1] = x.word.multi_green;
      mch[2] = x.word.multi_blue;
      a  = q_type'({24'd0, coef_a});
      b  = q_type'({24'd0, coef_b});
      nl = q_type'(x.nl);

      if (k == ST_PROD) begin
         for (int i = 0; i < 3; i++) begin
            y.prod[i]     = 32'(n[i] * l[i]);
            y.prod[3 + i] = 32'(n[i] * v[i]);
            y.prod[6 + i] = 32'(l[i] * v[i]);
         end
      end
      if (k == ST_DOT) begin
         y.nl = dot3(x.prod[0], x.prod[1], x.prod[2]);
         y.nv = dot3(x.prod[3], x.prod[4], x.prod[5]);
         if (y.nv < 0) begin
            y.nv = 32'sd0;
         end
         y.lv = dot3(x.prod[6], x.prod[7], x.prod[8]);
      end
      if (k == ST_MUL0) begin
         y.pdf_q  = smul(nl, INV_PI_Q, 30);
         y.nlnv   = smul(nl, q_type'(x.nv), 30);
         y.uc2    = smul(nl, nl, 30);
         y.va     = smul(nl, a, 16);
         y.m      = (x.nl > x.nv) ? nl : q_type'(x.nv);
         y.wd_rem = 64'($unsigned(x.nl)) << 30;
         y.wd_quo = '0;
      end
      if (k == ST_PREP) begin
         y.t      = q_type'(x.lv) - x.nlnv;
         y.pdf    = to_q16(x.pdf_q);
         y.sq_v   = 64'($unsigned(ONE_Q - x.uc2)) << 30;
         y.sq_res = '0;
      end
      if (k >= WD_FIRST && k <= WD_LAST) begin
         j = WD_LAST - k;
         d = 64'($unsigned(x.m)) << j;
         if (x.wd_rem >= d) begin
            y.wd_rem    = x.wd_rem - d;
            y.wd_quo[j] = 1'b1;
         end
      end
      if (k >= SQ_FIRST && k <= SQ_LAST) begin
         j     = k - SQ_FIRST;
         bit_v = 64'd1 << (62 - 2 * j);
         if (x.sq_v >= x.sq_res + bit_v) begin
            y.sq_v   = x.sq_v - (x.sq_res + bit_v);
            y.sq_res = (x.sq_res >> 1) + bit_v;
         end else begin
            y.sq_res = x.sq_res >> 1;
         end
      end
      if (k == ST_W) begin
         y.w = (x.t > 0) ? q_type'({9'd0, x.wd_quo}) : nl;
      end
      if (k == ST_TW) begin
         y.tw = smul(x.t, x.w, 30);
      end
      if (k == ST_ARG) begin
         y.vb     = smul(b, x.tw, 16);
         y.s      = q_type'(x.sq_res);
         y.su     = smul(y.s, nl, 30);
         y.ss     = smul(y.s, y.s, 30);
         y.sel_hi = nl >= y.s;
         arg      = y.sel_hi ? y.s : nl;
         pos      = 64'($unsigned(arg)) * 64'(ACOS_TABLE_DEPTH);
         y.idx    = IDX_BITS'(pos >> 30);
         y.frac   = pos[29:0];
      end
      if (k == ST_ROM) begin
         if (x.idx >= IDX_BITS'(ACOS_TABLE_DEPTH)) begin
            y.t0 = ASIN_ROM[ACOS_TABLE_DEPTH];
            y.t1 = ASIN_ROM[ACOS_TABLE_DEPTH];
         end else begin
            y.t0 = ASIN_ROM[x.idx];
            y.t1 = ASIN_ROM[IDX_BITS'(x.idx + 1'b1)];
         end
         y.s3 = smul(x.ss, x.s, 30);
      end
      if (k == ST_INTERP) begin
         ip = 61'(x.t1 - x.t0) * 61'(x.frac);
         if (x.t1 < x.t0) begin
            y.asin = q_type'({9'd0, x.t0});
         end else begin
            y.asin = q_type'({9'd0, x.t0}) + q_type'(ip >> 30);
         end
         y.p = smul(x.s, ONE_Q - x.s3, 30);
      end
      if (k == ST_THETA) begin
         y.theta  = x.sel_hi ? x.asin : HALF_PI_Q - x.asin;
         y.qd_rem = 64'($unsigned(x.p)) << 30;
         y.qd_ovf = y.qd_rem >= (64'($unsigned(nl)) << 33);
         y.qd_quo = '0;
      end
      if (k == ST_INNER) begin
         y.inner = x.theta - TWO_THIRDS_Q - x.su;
      end
      if (k >= QD_FIRST && k <= QD_LAST) begin
         j = QD_LAST - k;
         d = 64'($unsigned(nl)) << j;
         if (y.qd_rem >= d) begin
            y.qd_rem    = y.qd_rem - d;
            y.qd_quo[j] = 1'b1;
         end
      end
      if (k == ST_TERM1) begin
         y.term1 = smul(x.s, x.inner, 30);
      end
      if (k == ST_QCLAMP) begin
         y.q = (x.qd_ovf || x.qd_quo > GRAZE_MAX_Q) ? GRAZE_MAX_Q : x.qd_quo;
      end
      if (k == ST_G) begin
         gq = (64'($unsigned(TWO_THIRDS_Q)) * 64'(x.q)) >> 30;
         if (nl < EPS_Q) begin
            y.g = (HALF_PI_Q - TWO_THIRDS_Q) - nl;
         end else begin
            y.g = x.term1 + q_type'(gq);
         end
      end
      if (k == ST_E) begin
         y.ea = smul(a, PI_Q, 16);
         y.eb = smul(b, x.g, 16);
      end
      if (k == ST_E1) begin
         y.e1 = ONE_Q - (x.ea + x.eb);
      end
      if (k == ST_MC) begin
         for (int c = 0; c < 3; c++) begin
            y.mc[c] = smul(q_type'({24'd0, mch[c]}), x.e1, 16);
         end
      end
      if (k == ST_NM) begin
         for (int c = 0; c < 3; c++) begin
            y.nm[c] = smul(nl, $signed(x.mc[c]), 30);
         end
      end
      if (k == PIPE_LAST) begin
         if (x.nl <= 0) begin
            y.rsp = '0;
         end else if (coef_b == 16'd0) begin
            y.rsp.value_red   = x.pdf;
            y.rsp.value_green = x.pdf;
            y.rsp.value_blue  = x.pdf;
            y.rsp.density     = x.pdf;
         end else begin
            y.rsp.value_red   = to_q16(x.va + x.vb + $signed(x.nm[0]));
            y.rsp.value_green = to_q16(x.va + x.vb + $signed(x.nm[1]));
            y.rsp.value_blue  = to_q16(x.va + x.vb + $signed(x.nm[2]));
            y.rsp.density     = x.pdf;
         end
      end
      return y;
   endfunction

endpackage

`default_nettype wire

@@ rtl/onb_if.sv @@
// onb_if: valid/ready channel interfaces for request, response and csr words
// depends on onb_pkg for the word types
`timescale 1ns / 1ps
`default_nettype none

interface onb_req_if;
   import onb_pkg::*;
   logic         valid;
   logic         ready;
   req_word_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface onb_rsp_if;
   import onb_pkg::*;
   logic         valid;
   logic         ready;
   rsp_word_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface onb_csr_if;
   import onb_pkg::*;
   logic         valid;
   logic         ready;
   csr_word_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/oren_nayar_brdf_eval_top.sv @@
// oren_nayar_brdf_eval_top: Oren-Nayar reflectance pipeline, one word per cycle
// when not stalled; depends on onb_pkg and the channel interfaces in onb_if
//
// req_bus takes one shading word (normal, view, light in signed Q1.15 and the
// multiscatter color in Q0.16); rsp_bus returns value_red/green/blue and
// density in Q0.16, one response word per request word, in order.
// csr_bus writes coef_a (index 0) and coef_b (index 1); other indexes are
// dropped; it is always ready. Write it only while the pipeline is empty.
// Throughput is one word per cycle while rsp ready keeps the pipeline moving.
// Depth is set by the 32-step square root followed by the 33-step grazing
// divider, each step one pipeline stage.
// Reset clears every stage valid bit and loads coef_a = 20861, coef_b = 0.
// When rsp ready is low with a word waiting, the whole pipeline holds and
// req ready drops; nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module oren_nayar_brdf_eval_top (
   input  logic        clock,
   input  logic        reset,
   onb_req_if.sink     req_bus,
   onb_rsp_if.source   rsp_bus,
   onb_csr_if.sink     csr_bus
);
   import onb_pkg::*;

   logic [15:0]        coef_a_ff;
   logic [15:0]        coef_b_ff;
   item_type           pipe_ff [0:PIPE_LAST];
   item_type           pipe_in [0:PIPE_LAST];
   logic [PIPE_LAST:0] valid_ff;
   logic [PIPE_LAST:0] valid_in;
   logic               advance;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_a_ff <= COEF_A_RESET;
         coef_b_ff <= COEF_B_RESET;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.data.index)
            CSR_COEF_A: coef_a_ff <= csr_bus.data.wdata;
            CSR_COEF_B: coef_b_ff <= csr_bus.data.wdata;
            default: ;
         endcase
      end
   end

   assign advance       = !valid_ff[PIPE_LAST] || rsp_bus.ready;
   assign req_bus.ready = advance;
   assign valid_in      = {valid_ff[PIPE_LAST-1:0], req_bus.valid};

   always_comb begin
      pipe_in[0]      = '0;
      pipe_in[0].word = req_bus.data;
   end

   for (genvar k = 1; k <= PIPE_LAST; k++) begin : g_stage
      always_comb begin
         pipe_in[k] = step_fn(k, pipe_ff[k-1], coef_a_ff, coef_b_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k <= PIPE_LAST; k++) begin
            pipe_ff[k] <= pipe_in[k];
         end
      end
   end

   assign rsp_bus.valid = valid_ff[PIPE_LAST];
   assign rsp_bus.data  = pipe_ff[PIPE_LAST].rsp;

`ifndef ASSERT_OFF
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(valid_ff))
      else $error("pipeline valid bits moved while stalled");

   a_out_from_prev: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_bus.valid) |-> $past(valid_ff[PIPE_LAST-1]))
      else $error("response word appeared without a word in the stage before");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (valid_ff == '0))
      else $error("pipeline not empty after reset");
`endif

endmodule

`default_nettype wire
